### src/lidar_packet_framer_decoder_assert.svh
// assertion macros for the lidar packet framer decoder
`ifndef LIDAR_PACKET_FRAMER_DECODER_ASSERT_SVH
`define LIDAR_PACKET_FRAMER_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define LPFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lpfd assertion failed");

`define LPFD_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("lpfd assertion failed");

`else

`define LPFD_ASSERT(lbl, prop)

`define LPFD_NEVER(lbl, cond)

`endif

`endif

### src/lpfd_pkg.sv
// shared types and constants of the lidar packet framer decoder
package lpfd_pkg;

	localparam int BYTE_IDX_W = 6;
	localparam int DIST_W = 14;
	localparam int RAW_W = 15;
	localparam int ANGLE_W = 17;
	localparam int CFG_IDX_W = 1;
	localparam int NUM_SAMPLES = 8;
	localparam int SAMPLE_IDX_W = 3;

	localparam logic [7:0] SYNC_A = 8'h55;
	localparam logic [7:0] SYNC_B = 8'hAA;
	localparam logic [7:0] HDR_A = 8'h03;
	localparam logic [7:0] HDR_B = 8'h08;

	localparam logic [BYTE_IDX_W-1:0] POS_HDR_A = 6'd2;
	localparam logic [BYTE_IDX_W-1:0] POS_HDR_B = 6'd3;
	localparam logic [BYTE_IDX_W-1:0] POS_START_LO = 6'd6;
	localparam logic [BYTE_IDX_W-1:0] POS_START_HI = 6'd7;
	localparam logic [BYTE_IDX_W-1:0] POS_END_LO = 6'd32;
	localparam logic [BYTE_IDX_W-1:0] POS_END_HI = 6'd33;
	localparam logic [BYTE_IDX_W-1:0] POS_LAST = 6'd35;
	localparam int POS_DIST0 = 8;
	localparam int DIST_STRIDE = 3;

	localparam logic signed [17:0] ANGLE_BIAS = 18'sd40960;
	localparam logic signed [17:0] FULL_TURN_Q6 = 18'sd23040;

	// x / 7 == (x * DIV7_MUL) >> DIV7_SHIFT for x below 2^18
	localparam logic [17:0] DIV7_MUL = 18'd149797;
	localparam int DIV7_SHIFT = 20;
	localparam logic [2:0] SEVEN = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'b1;
	localparam logic [DIST_W-1:0] MIN_DIST_RESET = 14'd0;
	localparam logic [DIST_W-1:0] MAX_DIST_RESET = 14'd16383;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_HUNT_A = 3'b001,
		PH_HUNT_B = 3'b010,
		PH_RECV   = 3'b100
	} sync_phase_t;

	typedef enum logic [4:0] {
		BK_IDLE = 5'b00001,
		BK_DIFF = 5'b00010,
		BK_DIV  = 5'b00100,
		BK_REM  = 5'b01000,
		BK_RUN  = 5'b10000
	} back_state_t;

	typedef struct packed {
		logic [15:0] ang_start;
		logic [15:0] ang_end;
		logic [NUM_SAMPLES-1:0][RAW_W-1:0] dist_raw;
	} pkt_desc_t;

endpackage

### src/lpfd_front.sv
// byte framer: sync hunt, packet capture and header check
`include "lidar_packet_framer_decoder_assert.svh"

module lpfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               q_full,
	output logic               push_valid,
	output lpfd_pkg::pkt_desc_t push_data
);
	import lpfd_pkg::*;

	sync_phase_t phase_q;
	logic [BYTE_IDX_W-1:0] byte_index_q;
	logic [7:0] hdr_a_q;
	logic [7:0] hdr_b_q;
	logic [15:0] ang_start_q;
	logic [15:0] ang_end_q;
	logic [NUM_SAMPLES-1:0][RAW_W-1:0] dist_q;
	logic finish;
	logic take;

	assign finish = (phase_q == PH_RECV) && (byte_index_q == POS_LAST);
	assign in_stall = finish && q_full;
	assign take = in_valid && !in_stall;

	assign push_valid = take && finish && (hdr_a_q == HDR_A) && (hdr_b_q == HDR_B);
	assign push_data.ang_start = ang_start_q;
	assign push_data.ang_end = ang_end_q;
	assign push_data.dist_raw = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_A;
			byte_index_q <= '0;
		end else if (take) begin
			case (phase_q)
				PH_HUNT_A: begin
					phase_q <= (rx_byte == SYNC_A) ? PH_HUNT_B : PH_HUNT_A;
				end
				PH_HUNT_B: begin
					if (rx_byte == SYNC_B) begin
						phase_q <= PH_RECV;
						byte_index_q <= POS_HDR_A;
					end else begin
						phase_q <= PH_HUNT_A;
					end
				end
				PH_RECV: begin
					if (finish) begin
						phase_q <= PH_HUNT_A;
						byte_index_q <= '0;
					end else begin
						byte_index_q <= byte_index_q + 1'b1;
					end
				end
				default: begin
					phase_q <= PH_HUNT_A;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && (phase_q == PH_RECV)) begin
			if (byte_index_q == POS_HDR_A) hdr_a_q <= rx_byte;
			if (byte_index_q == POS_HDR_B) hdr_b_q <= rx_byte;
			if (byte_index_q == POS_START_LO) ang_start_q[7:0] <= rx_byte;
			if (byte_index_q == POS_START_HI) ang_start_q[15:8] <= rx_byte;
			if (byte_index_q == POS_END_LO) ang_end_q[7:0] <= rx_byte;
			if (byte_index_q == POS_END_HI) ang_end_q[15:8] <= rx_byte;
			for (int k = 0; k < NUM_SAMPLES; k++) begin
				if (byte_index_q == BYTE_IDX_W'(POS_DIST0 + DIST_STRIDE * k))
					dist_q[k][7:0] <= rx_byte;
				if (byte_index_q == BYTE_IDX_W'(POS_DIST0 + DIST_STRIDE * k + 1))
					dist_q[k][RAW_W-1:8] <= rx_byte[RAW_W-9:0];
			end
		end
	end

	`LPFD_NEVER(a_byte_index_range, byte_index_q > POS_LAST)

endmodule

### src/lpfd_queue.sv
// two-entry packet queue between framer and sample generator
`include "lidar_packet_framer_decoder_assert.svh"

module lpfd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  lpfd_pkg::pkt_desc_t push_data,
	output logic               full,
	output logic               head_valid,
	output lpfd_pkg::pkt_desc_t head,
	input  logic               pop
);
	import lpfd_pkg::*;

	pkt_desc_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = entry_q[rd_ptr_q];
	assign do_push = push_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

	`LPFD_NEVER(a_no_overflow, push_valid && full)
	`LPFD_NEVER(a_no_underflow, pop && !head_valid)

endmodule

### src/lpfd_back.sv
// sample generator: angle interpolation, distance range check, output register
`include "lidar_packet_framer_decoder_assert.svh"

module lpfd_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lpfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpfd_pkg::DIST_W-1:0]          cfg_data,
	input  logic                                 head_valid,
	input  lpfd_pkg::pkt_desc_t                  head,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [lpfd_pkg::SAMPLE_IDX_W-1:0]    sample_index,
	output logic signed [lpfd_pkg::ANGLE_W-1:0]  angle_q6,
	output logic [lpfd_pkg::DIST_W-1:0]          distance_mm,
	output logic                                 accepted,
	output logic                                 last
);
	import lpfd_pkg::*;

	back_state_t state_q;
	logic [DIST_W-1:0] min_dist_q;
	logic [DIST_W-1:0] max_dist_q;
	logic signed [ANGLE_W-1:0] s_q;
	logic neg_q;
	logic [15:0] mag_q;
	logic [13:0] dq_q;
	logic [2:0] dr_q;
	logic [15:0] q_acc_q;
	logic [2:0] r_acc_q;
	logic [SAMPLE_IDX_W-1:0] k_q;
	logic out_valid_q;
	logic [SAMPLE_IDX_W-1:0] sample_index_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic [DIST_W-1:0] distance_q;
	logic accepted_q;
	logic last_q;

	logic signed [17:0] s_w;
	logic signed [17:0] e_w;
	logic signed [17:0] e_adj_w;
	logic signed [17:0] diff_w;
	logic [17:0] abs_w;
	logic [33:0] prod_w;
	logic [16:0] seven_dq_w;
	logic [16:0] rem_w;
	logic [3:0] r_sum_w;
	logic signed [17:0] q_signed_w;
	logic signed [17:0] ang_w;
	logic [RAW_W-1:0] raw_w;
	logic [DIST_W-1:0] dist_w;
	logic slot_free;
	logic load;

	always_comb begin
		s_w = $signed({2'b00, head.ang_start}) - ANGLE_BIAS;
		e_w = $signed({2'b00, head.ang_end}) - ANGLE_BIAS;
		e_adj_w = (e_w < s_w) ? (e_w + FULL_TURN_Q6) : e_w;
		diff_w = e_adj_w - s_w;
		abs_w = diff_w[17] ? 18'(-diff_w) : 18'(diff_w);
		prod_w = 34'(mag_q) * 34'(DIV7_MUL);
		seven_dq_w = {dq_q, 3'b000} - {3'b000, dq_q};
		rem_w = {1'b0, mag_q} - seven_dq_w;
		r_sum_w = {1'b0, r_acc_q} + {1'b0, dr_q};
		q_signed_w = neg_q ? -$signed({2'b00, q_acc_q}) : $signed({2'b00, q_acc_q});
		ang_w = {s_q[ANGLE_W-1], s_q} + q_signed_w;
		raw_w = head.dist_raw[k_q];
		dist_w = raw_w[DIST_W-1:0];
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign load = (state_q == BK_RUN) && slot_free;
	assign pop = load && (k_q == SAMPLE_IDX_W'(NUM_SAMPLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= MIN_DIST_RESET;
			max_dist_q <= MAX_DIST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_DISTANCE: min_dist_q <= cfg_data;
				CFG_MAX_DISTANCE: max_dist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				BK_IDLE: if (head_valid) state_q <= BK_DIFF;
				BK_DIFF: state_q <= BK_DIV;
				BK_DIV: state_q <= BK_REM;
				BK_REM: state_q <= BK_RUN;
				BK_RUN: begin
					if (load) begin
						k_q <= k_q + 1'b1;
						if (pop) state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_DIFF: begin
				s_q <= s_w[ANGLE_W-1:0];
				neg_q <= diff_w[17];
				mag_q <= abs_w[15:0];
			end
			BK_DIV: begin
				dq_q <= prod_w[DIV7_SHIFT +: 14];
			end
			BK_REM: begin
				dr_q <= rem_w[2:0];
				q_acc_q <= '0;
				r_acc_q <= '0;
			end
			BK_RUN: begin
				if (load) begin
					if (r_sum_w >= {1'b0, SEVEN}) begin
						r_acc_q <= 3'(r_sum_w - {1'b0, SEVEN});
						q_acc_q <= q_acc_q + 16'(dq_q) + 16'd1;
					end else begin
						r_acc_q <= r_sum_w[2:0];
						q_acc_q <= q_acc_q + 16'(dq_q);
					end
				end
			end
			default: ;
		endcase
		if (load) begin
			sample_index_q <= k_q;
			angle_q <= ang_w[ANGLE_W-1:0];
			distance_q <= dist_w;
			accepted_q <= !raw_w[DIST_W] && (dist_w >= min_dist_q) && (dist_w <= max_dist_q);
			last_q <= (k_q == SAMPLE_IDX_W'(NUM_SAMPLES - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign sample_index = sample_index_q;
	assign angle_q6 = angle_q;
	assign distance_mm = distance_q;
	assign accepted = accepted_q;
	assign last = last_q;

	`LPFD_NEVER(a_rem_range, (state_q == BK_RUN) && (r_acc_q > 3'd6))
	`LPFD_ASSERT(a_idle_k_clear, (state_q == BK_IDLE) |-> (k_q == '0))
	`LPFD_ASSERT(a_pop_marks_last, pop |=> (out_valid_q && last_q))

endmodule

### src/lidar_packet_framer_decoder.sv
// top level: rangefinder packet framer and sample decoder
// output: after a good packet's last byte is taken, the sample generator passes its diff, divide
// and remainder states, then 8 samples follow one per cycle while out_stall is low.
// throughput: one byte per cycle; the framer stalls on a packet's last byte only
// when the two-entry packet queue is full.
// reset: asynchronous, active low; returns to sync hunt, distance limits 0 and 16383.
module lidar_packet_framer_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lpfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpfd_pkg::DIST_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [lpfd_pkg::SAMPLE_IDX_W-1:0]    sample_index,
	output logic signed [lpfd_pkg::ANGLE_W-1:0]  angle_q6,
	output logic [lpfd_pkg::DIST_W-1:0]          distance_mm,
	output logic                                 accepted,
	output logic                                 last
);
	import lpfd_pkg::*;

	logic q_full;
	logic push_valid;
	pkt_desc_t push_data;
	logic head_valid;
	pkt_desc_t head;
	logic pop;

	lpfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	lpfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	lpfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_index (sample_index),
		.angle_q6     (angle_q6),
		.distance_mm  (distance_mm),
		.accepted     (accepted),
		.last         (last)
	);

endmodule
